// File: rtl/tkbt_pkg.sv
// ----------------------------------------------------------------------------
// tkbt_pkg
// shared types and constants of the top-k best tracker
// ----------------------------------------------------------------------------
`default_nettype none

package tkbt_pkg;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 7;
  localparam int SCORE_W  = 16;
  localparam int LIMIT_W  = 4;
  localparam int COUNT_W  = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic [SCORE_W-1:0]  candidate_score;
    logic [INDEX_W-1:0]  member_index;
    logic [ACTION_W-1:0] action;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] list_count;
    logic [INDEX_W-1:0] top_index;
    logic [INDEX_W-1:0] evicted_index;
    logic               evicted_valid;
    logic               is_member;
    logic               inserted;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tkbt_core.sv
// ----------------------------------------------------------------------------
// tkbt_core
// ranked list walk with one shared score comparator, plus membership flags
// ----------------------------------------------------------------------------
`default_nettype none

module tkbt_core #(
  parameter int LIST_DEPTH = 8,
  parameter int POPULATION = 128
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [tkbt_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  wire                          start,
  input  tkbt_pkg::item_t              item,
  output logic                         idle,
  output logic                         res_valid,
  input  wire                          res_ready,
  output tkbt_pkg::result_t            result
);
  import tkbt_pkg::*;

  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int FAW = $clog2(POPULATION);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ACTION_W-1:0]  act_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [SCORE_W-1:0]   cand_r;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic                 full_r, full_nxt;
  logic                 ins_r, ins_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [INDEX_W-1:0]   ev_index_r, ev_index_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [POPULATION-1:0] flags_r, flags_nxt;

  logic [INDEX_W-1:0]   rank_idx_r   [LIST_DEPTH];
  logic [SCORE_W-1:0]   rank_score_r [LIST_DEPTH];

  logic [AW-1:0]        rd_addr;
  logic [INDEX_W-1:0]   rd_idx;
  logic [SCORE_W-1:0]   rd_score;
  logic                 score_lt, score_eq;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [INDEX_W-1:0]   wr_idx;
  logic [SCORE_W-1:0]   wr_score;
  logic [CW-1:0]        lim_eff;
  logic                 in_pop;
  logic                 full_now;

  // effective limit clamped to 1..LIST_DEPTH
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = CW'(1);
    end else if (32'(limit_r) > LIST_DEPTH) begin
      lim_eff = CW'(LIST_DEPTH);
    end else begin
      lim_eff = CW'(limit_r);
    end
  end

  assign in_pop   = 32'(idx_r) < POPULATION;
  assign full_now = count_r >= lim_eff;

  // shared read port and comparator
  always_comb begin
    if (state_r == S_SHIFT) begin
      rd_addr = pos_r - AW'(1);
    end else begin
      rd_addr = AW'(count_r - CW'(1));
    end
  end

  assign rd_idx   = rank_idx_r[rd_addr];
  assign rd_score = rank_score_r[rd_addr];
  assign score_lt = rd_score < cand_r;
  assign score_eq = rd_score == cand_r;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    full_nxt     = full_r;
    ins_nxt      = ins_r;
    ev_valid_nxt = ev_valid_r;
    ev_index_nxt = ev_index_r;
    count_nxt    = count_r;
    flags_nxt    = flags_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_idx       = rd_idx;
    wr_score     = rd_score;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt    = S_CHECK;
          ins_nxt      = 1'b0;
          ev_valid_nxt = 1'b0;
          ev_index_nxt = '0;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (act_r == ACT_CLEAR) begin
          flags_nxt = '0;
          count_nxt = '0;
        end else if (act_r == ACT_OFFER && in_pop && !flags_r[FAW'(idx_r)]) begin
          if (!(full_now && !score_lt)) begin
            state_nxt = S_SHIFT;
            full_nxt  = full_now;
            if (full_now) begin
              pos_nxt      = AW'(count_r - CW'(1));
              ev_valid_nxt = 1'b1;
              ev_index_nxt = rd_idx;
              if (32'(rd_idx) < POPULATION) begin
                flags_nxt[FAW'(rd_idx)] = 1'b0;
              end
            end else begin
              pos_nxt = AW'(count_r);
            end
          end
        end
      end
      S_SHIFT: begin
        wr_en = 1'b1;
        if (pos_r != '0 && (score_lt || score_eq)) begin
          pos_nxt = pos_r - AW'(1);
        end else begin
          wr_idx                  = idx_r;
          wr_score                = cand_r;
          flags_nxt[FAW'(idx_r)]  = 1'b1;
          ins_nxt                 = 1'b1;
          state_nxt               = S_DONE;
          if (!full_r) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      flags_r    <= '0;
      limit_r    <= LIMIT_RESET;
      ins_r      <= 1'b0;
      ev_valid_r <= 1'b0;
      ev_index_r <= '0;
      full_r     <= 1'b0;
      pos_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      flags_r    <= flags_nxt;
      ins_r      <= ins_nxt;
      ev_valid_r <= ev_valid_nxt;
      ev_index_r <= ev_index_nxt;
      full_r     <= full_nxt;
      pos_r      <= pos_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      act_r  <= item.action;
      idx_r  <= item.member_index;
      cand_r <= item.candidate_score;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rank_idx_r[wr_addr]   <= wr_idx;
      rank_score_r[wr_addr] <= wr_score;
    end
  end

  assign idle      = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;

  always_comb begin
    result.inserted      = ins_r;
    result.is_member     = in_pop && flags_r[FAW'(idx_r)];
    result.evicted_valid = ev_valid_r;
    result.evicted_index = ev_index_r;
    result.top_index     = (count_r != '0) ? rank_idx_r[0] : '0;
    result.list_count    = COUNT_W'(count_r);
  end

endmodule

`default_nettype wire

// File: rtl/top_k_best_tracker_top.sv
// ----------------------------------------------------------------------------
// top_k_best_tracker_top
// keeps the best-scoring population indices in a ranked list with flags
// ----------------------------------------------------------------------------
// in channel: in_tuser carries the action (offer, query, clear), in_tdata
// the member index and its score. out channel: one result transfer per
// input transfer, in order. cfg_wr_en/cfg_wr_data set the group limit
// (reset value 5); write only while the block is idle.
// the list is walked one entry per cycle through a single score
// comparator. a query, a clear or a rejected offer goes through the check
// and done states; an inserting offer also enters the shift state for each
// entry it moves past. in_tready is low while an item is at work.
// the result sits in an output register; a new item may be accepted while
// it waits, but the next result is held inside until out_tready frees it.
// reset (rst_n low, synchronous) empties the list, clears all membership
// flags and the output valid, and restores the group limit.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_best_tracker_top #(
  parameter int LIST_DEPTH = 8,
  parameter int POPULATION = 128
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // member_index[6:0], candidate_score[22:7], zero fill
  input  wire [tkbt_pkg::IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  wire [tkbt_pkg::ACTION_W-1:0]    in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // inserted[0], is_member[1], evicted_valid[2], evicted_index[9:3],
  // top_index[16:10], list_count[20:17], zero fill
  output logic [tkbt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire                             cfg_wr_en,
  input  wire [tkbt_pkg::LIMIT_W-1:0]     cfg_wr_data
);
  import tkbt_pkg::*;

  localparam int RES_W = $bits(result_t);

  item_t   item;
  result_t result;
  logic    core_idle;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_r;
  result_t out_res_r;

  assign item.action          = in_tuser;
  assign item.member_index    = in_tdata[INDEX_W-1:0];
  assign item.candidate_score = in_tdata[INDEX_W +: SCORE_W];

  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  tkbt_core #(
    .LIST_DEPTH(LIST_DEPTH),
    .POPULATION(POPULATION)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start      (in_tvalid && in_tready),
    .item       (item),
    .idle       (core_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_res_r};

endmodule

`default_nettype wire

// File: rtl/tkbt_checker.sv
// ----------------------------------------------------------------------------
// tkbt_checker
// port-level checks of the top-k best tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tkbt_checker #(
  parameter int LIST_DEPTH = 8
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [tkbt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tkbt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transfer");

  // list never grows past its depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[20:17]) <= LIST_DEPTH)
    else $error("list count beyond depth");

  // an inserted index is a member
  a_ins_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("inserted index not flagged");

  // eviction only with an insertion
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tdata[2] && out_tdata[9:3] == '0)
    else $error("eviction without insertion");

endmodule

bind top_k_best_tracker_top tkbt_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_tkbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
